FILE: rtl/sha_pkg.sv
// ============================================================================
// sha_pkg
// types, constants and the rotate function shared by the sha-256 hasher modules
// ============================================================================
package sha_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LEN   = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_ADD   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       put_byte;
    logic [7:0] put_val;
    logic       add_len;
    logic       round_init;
    logic       round_step;
    logic       hash_add;
    logic       hash_reset;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [5:0] fill;
    logic [7:0] len_byte;
  } dp_sts_t;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t v, input int unsigned s);
    rotr = (v >> s) | (v << (WordW - s));
  endfunction

endpackage

FILE: rtl/sha256_byte_stream_hasher.sv
// ============================================================================
// sha256_byte_stream_hasher
// sha-256 of a byte stream: one byte per input transaction, eight digest words
// ============================================================================
// usage:
//   input channel (in_valid_i / in_stall_o): req_type_i 0 appends data_byte_i,
//   req_type_i 1 finishes the message.
//   output channel (out_valid_o / out_stall_i): eight digest words per finish,
//   word_index_o 0..7, last_word_o on the eighth.
// sequence:
//   a data byte is written into the block buffer; the 64th byte of a block also
//   runs the rounds and then the add step on the single shared round unit.
//   a finish walks the padding one byte a cycle up to the block end (one or
//   two blocks, each with its rounds and add step), then presents the eight words.
//   one transaction in flight; in_stall_o is high while it is worked on.
// reset: hash words return to the initial values, byte and bit counts clear.
// stall: a stalled digest word holds; the block waits until it is taken.
// after the last word the block restarts for the next message.
// ============================================================================
module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha_pkg::*;

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [5:0] rnd;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .data_byte_i,
    .out_valid_o, .out_stall_i, .word_index_o, .last_word_o,
    .cmd_o(cmd), .sts_i(sts), .rnd_o(rnd)
  );

  sha_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .rnd_i(rnd), .word_index_i(word_index_o),
    .sts_o(sts), .digest_word_o
  );

endmodule

FILE: rtl/sha_ctrl.sv
// ============================================================================
// sha_ctrl
// sequencer: byte intake, padding, length bytes, rounds and digest output
// ============================================================================
module sha_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             req_type_i,
  input  logic [7:0]       data_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       word_index_o,
  output logic             last_word_o,
  output sha_pkg::dp_cmd_t cmd_o,
  input  sha_pkg::dp_sts_t sts_i,
  output logic [5:0]       rnd_o
);
  import sha_pkg::*;

  state_e     state_q, state_d, ret_q, ret_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       in_acc, out_acc;

  assign in_acc       = in_valid_i && !in_stall_o;
  assign out_acc      = out_valid_o && !out_stall_i;
  assign in_stall_o   = state_q != ST_IDLE;
  assign out_valid_o  = state_q == ST_OUT;
  assign word_index_o = cnt_q;
  assign last_word_o  = cnt_q == 3'd7;
  assign rnd_o        = rnd_q;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    rnd_d   = rnd_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_o.put_byte = 1'b1;
          cnt_d = 3'd0;
          if (req_type_i) begin
            cmd_o.put_val = 8'h80;
            ret_d = (sts_i.fill == 6'd55) ? ST_LEN : ST_PAD;
          end else begin
            cmd_o.put_val = data_byte_i;
            cmd_o.add_len = 1'b1;
            ret_d = ST_IDLE;
          end
          if (sts_i.fill == 6'd63) begin
            state_d = ST_ROUND;
            cmd_o.round_init = 1'b1;
            rnd_d = 6'd0;
          end else begin
            state_d = ret_d;
          end
        end
      end
      ST_PAD: begin
        cmd_o.put_byte = 1'b1;
        if (sts_i.fill == 6'd63) begin
          state_d = ST_ROUND;
          cmd_o.round_init = 1'b1;
          rnd_d = 6'd0;
          ret_d = ST_PAD;
        end else if (sts_i.fill == 6'd55) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd_o.put_byte = 1'b1;
        cmd_o.put_val  = sts_i.len_byte;
        if (sts_i.fill == 6'd63) begin
          state_d = ST_ROUND;
          cmd_o.round_init = 1'b1;
          rnd_d = 6'd0;
          ret_d = ST_OUT;
        end
      end
      ST_ROUND: begin
        cmd_o.round_step = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.hash_add = 1'b1;
        state_d = ret_q;
      end
      ST_OUT: begin
        if (out_acc) begin
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd7) begin
            cmd_o.hash_reset = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      rnd_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      rnd_q   <= rnd_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: rtl/sha_dp.sv
// ============================================================================
// sha_dp
// block buffer, length counter, message schedule window, round and hash registers
// ============================================================================
module sha_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sha_pkg::dp_cmd_t cmd_i,
  input  logic [5:0]       rnd_i,
  input  logic [2:0]       word_index_i,
  output sha_pkg::dp_sts_t sts_o,
  output logic [31:0]      digest_word_o
);
  import sha_pkg::*;

  word_t       buf_q [16];
  word_t       w_q [16];
  word_t       r_q [8];
  word_t       h_q [8];
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [63:0] len_q;
  word_t       s0, s1, wnew, big1, ch, big0, maj, t1, t2;

  assign sts_o         = '{fill: fill_q, len_byte: len_q[63 - 8*fill_q[2:0] -: 8]};
  assign digest_word_o = h_q[word_index_i];

  always_comb begin
    s0   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    big1 = rotr(r_q[4], 6) ^ rotr(r_q[4], 11) ^ rotr(r_q[4], 25);
    ch   = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
    t1   = r_q[7] + big1 + ch + RoundK[rnd_i] + w_q[0];
    big0 = rotr(r_q[0], 2) ^ rotr(r_q[0], 13) ^ rotr(r_q[0], 22);
    maj  = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
    t2   = big0 + maj;
  end

  // payload storage, message schedule window and round registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.put_byte) begin
      if (fill_q[1:0] == 2'd0) begin
        buf_q[fill_q[5:2]] <= {cmd_i.put_val, 24'd0};
      end else begin
        buf_q[fill_q[5:2]][31 - 8*fill_q[1:0] -: 8] <= cmd_i.put_val;
      end
    end
    if (cmd_i.round_init) begin
      for (int i = 0; i < 15; i++) w_q[i] <= buf_q[i];
      w_q[15] <= {buf_q[15][31:8], cmd_i.put_val};
      r_q <= h_q;
    end else if (cmd_i.round_step) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
      r_q[7] <= r_q[6];
      r_q[6] <= r_q[5];
      r_q[5] <= r_q[4];
      r_q[4] <= r_q[3] + t1;
      r_q[3] <= r_q[2];
      r_q[2] <= r_q[1];
      r_q[1] <= r_q[0];
      r_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bits_q <= '0;
      len_q  <= '0;
      h_q    <= InitHash;
    end else begin
      if (cmd_i.put_byte) begin
        fill_q <= fill_q + 6'd1;
      end
      if (cmd_i.add_len) begin
        bits_q <= bits_q + 64'd8;
      end else if (cmd_i.put_byte && cmd_i.put_val == 8'h80 && !cmd_i.round_step
                   && len_q != bits_q) begin
        len_q <= bits_q;
      end
      if (cmd_i.add_len) begin
        len_q <= bits_q + 64'd8;
      end
      if (cmd_i.hash_add) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + r_q[i];
      end
      if (cmd_i.hash_reset) begin
        h_q    <= InitHash;
        bits_q <= '0;
        len_q  <= '0;
        fill_q <= '0;
      end
    end
  end

endmodule
